@@ rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and character constants for the source line lock encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

	// register map
	localparam logic REG_KEY_LENGTH  = 1'b0;
	localparam logic REG_KEY_ENTRIES = 1'b1;

	// register and key geometry
	localparam int KEY_LEN_W = 4;
	localparam int KEY_REG_W = 48;
	localparam int KEY_BITS  = 6;
	localparam int KEY_SLOTS = KEY_REG_W / KEY_BITS;

	// character codes
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] CH_SEMI     = 8'd59;
	localparam logic [7:0] CH_COMMA    = 8'd44;
	localparam logic [7:0] CH_BS       = 8'd8;
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_LOWER_A  = 8'd97;
	localparam logic [7:0] CH_LOWER_Z  = 8'd122;
	localparam logic [7:0] CASE_OFFSET = 8'd32;
	localparam logic [7:0] CTRL_MAX    = 8'd31;
	localparam logic [7:0] HIGH_MIN    = 8'd128;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// one classified item: a byte to cipher, or a line end marker
	typedef struct packed {
		logic       eol;
		logic [7:0] data;
	} sle_entry_t;

endpackage

`default_nettype wire

@@ rtl/sle_front.sv @@
// ----------------------------------------------------------------------------
// sle_front
// Upper-cases bytes, drops comments, collapses separator runs and tracks
// whether the current line has produced output.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     accept,
	input  wire                     func,
	input  wire  [7:0]              char_byte,
	output logic                    push,
	output sle_pkg::sle_entry_t     push_entry
);
	import sle_pkg::*;

	logic       in_comment_q;
	logic       in_token_q;
	logic       line_has_output_q;
	logic [7:0] upper;
	logic       is_sep;

	logic       in_comment_d;
	logic       in_token_d;
	logic       line_has_output_d;

	// upper-case a..z
	always_comb begin
		if (char_byte >= CH_LOWER_A && char_byte <= CH_LOWER_Z) begin
			upper = char_byte - CASE_OFFSET;
		end else begin
			upper = char_byte;
		end
	end

	assign is_sep = (upper == CH_SPACE) || (upper == CH_BS) || (upper == CH_TAB) ||
		(upper == CH_LF) || (upper == CH_COMMA);

	// classify the item
	always_comb begin
		push              = 1'b0;
		push_entry.eol    = 1'b0;
		push_entry.data   = upper;
		in_comment_d      = in_comment_q;
		in_token_d        = in_token_q;
		line_has_output_d = line_has_output_q;
		if (func) begin
			push              = line_has_output_q;
			push_entry.eol    = 1'b1;
			push_entry.data   = 8'd0;
			in_comment_d      = 1'b0;
			in_token_d        = 1'b0;
			line_has_output_d = 1'b0;
		end else if (in_comment_q) begin
			push = 1'b0;
		end else if (upper == CH_SEMI) begin
			in_comment_d = 1'b1;
		end else if (is_sep) begin
			if (in_token_q) begin
				push              = 1'b1;
				push_entry.data   = CH_SPACE;
				in_token_d        = 1'b0;
				line_has_output_d = 1'b1;
			end
		end else begin
			push              = 1'b1;
			in_token_d        = 1'b1;
			line_has_output_d = 1'b1;
		end
		if (!accept) begin
			push = 1'b0;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q      <= 1'b0;
			in_token_q        <= 1'b0;
			line_has_output_q <= 1'b0;
		end else if (accept) begin
			in_comment_q      <= in_comment_d;
			in_token_q        <= in_token_d;
			line_has_output_q <= line_has_output_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sle_queue.sv @@
// ----------------------------------------------------------------------------
// sle_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_queue (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  sle_pkg::sle_entry_t     push_entry,
	input  wire                     pop,
	output logic                    full,
	output logic                    not_empty,
	output sle_pkg::sle_entry_t     head
);
	import sle_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sle_entry_t         entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'((CNT_W'(wr_ptr_q) + CNT_W'(1)) % CNT_W'(QUEUE_DEPTH));
			end
			if (do_pop) begin
				rd_ptr_q <= PTR_W'((CNT_W'(rd_ptr_q) + CNT_W'(1)) % CNT_W'(QUEUE_DEPTH));
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/sle_back.sv @@
// ----------------------------------------------------------------------------
// sle_back
// Ciphers queued bytes with the cycling key and the previous plain nibble, or
// passes them uncoded at key length zero, and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_back #(
	parameter int KEY_MAX = 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire  [sle_pkg::KEY_LEN_W-1:0]   key_length,
	input  wire  [sle_pkg::KEY_REG_W-1:0]   key_entries,
	input  wire                             head_valid,
	input  sle_pkg::sle_entry_t             head,
	output logic                            pop,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [7:0]                      out_data,
	output logic                            out_last
);
	import sle_pkg::*;

	localparam int KIW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

	logic [KIW-1:0]        key_index_q;
	logic [3:0]            prev_nibble_q;
	logic                  out_valid_q;
	logic [7:0]            out_data_q;
	logic                  out_last_q;

	logic [KEY_LEN_W-1:0]  len_eff;
	logic [KEY_LEN_W-1:0]  idx_w;
	logic [KEY_LEN_W-1:0]  pos;
	logic [KEY_LEN_W-1:0]  pos_next;
	logic [KEY_BITS-1:0]   key;
	logic [7:0]            plain;
	logic [7:0]            coded;
	logic                  ciphering;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	// key position and key select
	always_comb begin
		if (key_length > KEY_LEN_W'(KEY_MAX)) begin
			len_eff = KEY_LEN_W'(KEY_MAX);
		end else begin
			len_eff = key_length;
		end
		idx_w = KEY_LEN_W'(key_index_q);
		pos   = (idx_w >= len_eff) ? '0 : idx_w;
		if (pos + KEY_LEN_W'(1) >= len_eff) begin
			pos_next = '0;
		end else begin
			pos_next = pos + KEY_LEN_W'(1);
		end
		key = '0;
		if (pos < KEY_LEN_W'(KEY_SLOTS)) begin
			key = key_entries[pos[2:0]*KEY_BITS +: KEY_BITS];
		end
	end

	// substitution and cipher
	always_comb begin
		if (head.data <= CTRL_MAX || head.data >= HIGH_MIN) begin
			plain = CH_SPACE;
		end else begin
			plain = head.data;
		end
		coded = (plain ^ {2'b00, key} ^ {4'b0000, prev_nibble_q}) + 8'd1;
		ciphering = pop && !head.eol && (key_length != '0);
	end

	// cipher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_index_q   <= '0;
			prev_nibble_q <= '0;
		end else if (ciphering) begin
			key_index_q   <= KIW'(pos_next);
			prev_nibble_q <= plain[3:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_last_q <= head.eol;
			if (head.eol) begin
				out_data_q <= 8'd0;
			end else if (key_length == '0) begin
				out_data_q <= head.data;
			end else begin
				out_data_q <= coded;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/source_line_lock_encoder.sv @@
// ----------------------------------------------------------------------------
// source_line_lock_encoder
// Locks source text lines: upper-case, comment strip, separator collapse,
// and a key and nibble chained byte cipher.
// ----------------------------------------------------------------------------
// Takes one text byte or end-of-line marker per cycle and gives at most one
// coded byte per cycle; a byte passes through the queue storage and then the
// output register (front classify into a four-entry queue, back cipher into
// the output register). Input is held off only while the queue is full, which
// happens when the output side stalls. Keys are to be written through the
// configuration port while the block is idle; the block does not enforce this.
`default_nettype none

module source_line_lock_encoder #(
	parameter int KEY_MAX = 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	// configuration writes
	input  wire                             cfg_we,
	input  wire                             cfg_index,
	input  wire  [sle_pkg::KEY_REG_W-1:0]   cfg_wdata,
	// input stream
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [7:0]                      s_tdata,   // [7:0] char_byte
	input  wire                             s_tuser,   // [0] func
	// output stream
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] coded_byte
	output logic                            m_tlast    // line_end
);
	import sle_pkg::*;

	logic [KEY_LEN_W-1:0]  key_length_q;
	logic [KEY_REG_W-1:0]  key_entries_q;
	logic                  s_accept;
	logic                  push;
	sle_entry_t            push_entry;
	logic                  q_full;
	logic                  q_not_empty;
	sle_entry_t            q_head;
	logic                  pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q  <= KEY_LEN_W'(1);
			key_entries_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LENGTH:  key_length_q  <= cfg_wdata[KEY_LEN_W-1:0];
				REG_KEY_ENTRIES: key_entries_q <= cfg_wdata;
				default:         key_length_q  <= key_length_q;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign s_accept = s_tvalid && s_tready;

	sle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_accept),
		.func       (s_tuser),
		.char_byte  (s_tdata),
		.push       (push),
		.push_entry (push_entry)
	);

	sle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	sle_back #(
		.KEY_MAX (KEY_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_length  (key_length_q),
		.key_entries (key_entries_q),
		.head_valid  (q_not_empty),
		.head        (q_head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_last    (m_tlast)
	);

endmodule

`default_nettype wire

@@ rtl/sle_checker.sv @@
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks for the source line lock encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_checker (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             m_tvalid,
	input  wire                             m_tready,
	input  wire  [7:0]                      m_tdata,
	input  wire                             m_tlast
);
	// last output transfer was a line end (start counts as one)
	logic last_was_eol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_was_eol_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			last_was_eol_q <= m_tlast;
		end
	end

	// no output once reset has been seen by the clock
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid during reset");

	// a line end carries a zero byte
	a_eol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == 8'd0)
		else $error("line end with nonzero data");

	// empty lines give no line end
	a_no_empty_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !last_was_eol_q)
		else $error("line end without coded bytes");

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

endmodule

bind source_line_lock_encoder sle_checker u_sle_checker (.*);

`default_nettype wire

@@ tb/sv/source_line_lock_encoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// source_line_lock_encoder_tb
// Streams directed and random source lines through the lock encoder under
// several key settings, with random idling on both stream sides, and checks
// every coded byte and line end against a cycle-free model of the cipher.
// ----------------------------------------------------------------------------

module source_line_lock_encoder_tb;

	import sle_pkg::*;

	localparam int KEY_MAX      = 8;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 75;
	localparam int IDLE_PCT     = 21;

	typedef enum bit {
		FN_TEXT = 1'b0,
		FN_EOL  = 1'b1
	} func_e;

	typedef struct packed {
		func_e      func;
		logic [7:0] char_byte;
	} text_item_t;

	// expected coded stream, built from accepted input transfers
	class line_lock_scoreboard;
		typedef struct {
			logic [7:0] coded;
			logic       line_end;
		} coded_item_t;

		coded_item_t pending_codes[$];
		bit [3:0]    key_len = 4'd1;
		bit [47:0]   key_reg = '0;
		int unsigned key_idx = 0;
		bit [3:0]    prev_nibble = '0;
		bit          in_comment = 1'b0;
		bit          in_token = 1'b0;
		bit          line_has_output = 1'b0;
		int          errors = 0;

		function void set_register(logic idx, logic [KEY_REG_W-1:0] value);
			if (idx == REG_KEY_LENGTH)
				key_len = value[KEY_LEN_W-1:0];
			else
				key_reg = value;
		endfunction

		// key and previous-nibble chained cipher of one surviving byte
		function bit [7:0] lock_byte(bit [7:0] b);
			int unsigned span;
			int unsigned pos;
			bit [5:0]    key;
			bit [7:0]    plain;
			bit [7:0]    coded;
			span = key_len;
			if (span == 0)
				return b;
			if (span > KEY_MAX)
				span = KEY_MAX;
			pos = (key_idx >= span) ? 0 : key_idx;
			key_idx = (pos + 1 >= span) ? 0 : pos + 1;
			key = key_reg[pos*KEY_BITS +: KEY_BITS];
			plain = (b <= CTRL_MAX || b >= HIGH_MIN) ? CH_SPACE : b;
			coded = (plain ^ {2'b00, key} ^ {4'h0, prev_nibble}) + 8'd1;
			prev_nibble = plain[3:0];
			return coded;
		endfunction

		function void take_input(func_e func, bit [7:0] b);
			bit [7:0]    ch;
			bit          had;
			coded_item_t item;
			// end of line closes comment and token, marks nonempty lines
			if (func == FN_EOL) begin
				had = line_has_output;
				in_comment = 1'b0;
				in_token = 1'b0;
				line_has_output = 1'b0;
				if (had) begin
					item.coded = 8'd0;
					item.line_end = 1'b1;
					pending_codes.push_back(item);
				end
				return;
			end
			if (in_comment)
				return;
			ch = b;
			if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
				ch = ch - CASE_OFFSET;
			if (ch == CH_SEMI) begin
				in_comment = 1'b1;
				return;
			end
			// separator runs collapse to one space after a token
			if (ch == CH_SPACE || ch == CH_BS || ch == CH_TAB || ch == CH_LF
					|| ch == CH_COMMA) begin
				if (!in_token)
					return;
				in_token = 1'b0;
				ch = CH_SPACE;
			end else begin
				in_token = 1'b1;
			end
			line_has_output = 1'b1;
			item.coded = lock_byte(ch);
			item.line_end = 1'b0;
			pending_codes.push_back(item);
		endfunction

		function void check_coded(logic [7:0] coded, logic line_end);
			coded_item_t want;
			if (pending_codes.size() == 0) begin
				$display("%0t: unexpected result coded_byte=%h line_end=%b",
					$time, coded, line_end);
				errors++;
				return;
			end
			want = pending_codes.pop_front();
			if (coded !== want.coded) begin
				$display("%0t: coded_byte expected %h actual %h",
					$time, want.coded, coded);
				errors++;
			end
			if (line_end !== want.line_end) begin
				$display("%0t: line_end expected %b actual %b",
					$time, want.line_end, line_end);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = 1'b0;
	logic [KEY_REG_W-1:0] cfg_wdata = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;   // [7:0] char_byte
	logic                 s_tuser = 1'b0; // [0] func
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;        // [7:0] coded_byte
	logic                 m_tlast;        // line_end

	int in_idle_pct = IDLE_PCT;
	int out_idle_pct = IDLE_PCT;

	line_lock_scoreboard sb = new();

	localparam bit [3:0] PHASE_LEN [NUM_PHASES] = '{4'd15, 4'd3, 4'd0, 4'd1,
		4'd8, 4'd11, 4'd5, 4'd2};

	// separators, case edges, control and high bytes, comments, empty lines
	text_item_t directed_items [24] = '{
		{FN_TEXT, CH_SPACE}, {FN_TEXT, CH_TAB}, {FN_TEXT, CH_LOWER_A},
		{FN_TEXT, CH_LOWER_Z}, {FN_TEXT, CH_BS}, {FN_TEXT, CH_LF},
		{FN_TEXT, CH_COMMA}, {FN_TEXT, 8'h00}, {FN_TEXT, CTRL_MAX},
		{FN_TEXT, 8'h7F}, {FN_TEXT, HIGH_MIN}, {FN_TEXT, 8'hFF},
		{FN_TEXT, 8'h7B}, {FN_TEXT, CH_SEMI}, {FN_TEXT, 8'h62},
		{FN_EOL, 8'hFF}, {FN_EOL, 8'h00}, {FN_TEXT, CH_SEMI},
		{FN_TEXT, 8'h71}, {FN_EOL, 8'h55}, {FN_TEXT, CH_COMMA},
		{FN_TEXT, 8'h60}, {FN_TEXT, 8'h41}, {FN_EOL, 8'hAA}
	};

	source_line_lock_encoder #(
		.KEY_MAX(KEY_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// output side stalls at random
	always @(negedge clk) begin
		m_tready <= arst_n && ($urandom_range(0, 99) >= out_idle_pct);
	end

	// check every output transfer
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready)
			sb.check_coded(m_tdata, m_tlast);
	end

	// register write while idle, starts and ends at a falling edge
	task write_reg(input logic idx, input logic [KEY_REG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		sb.set_register(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// one input transfer with random idle cycles ahead of it
	task send_item(input func_e func, input logic [7:0] b);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.take_input(func, b);
		@(negedge clk);
	endtask

	// stop sending and let every expected result arrive
	task drain;
		s_tvalid <= 1'b0;
		while (sb.pending_codes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// mostly source-like bytes, some separators, comments and raw bytes
	function logic [7:0] text_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return CH_LOWER_A + 8'($urandom_range(0, 25));
		else if (r < 40)
			return 8'h41 + 8'($urandom_range(0, 25));
		else if (r < 52)
			return 8'($urandom_range(33, 126));
		else if (r < 58)
			return CH_SPACE;
		else if (r < 62)
			return CH_TAB;
		else if (r < 65)
			return CH_BS;
		else if (r < 68)
			return CH_LF;
		else if (r < 72)
			return CH_COMMA;
		else if (r < 75)
			return CH_SEMI;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task send_lines(input int count);
		int sent;
		int len;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(0, 14);
			repeat (len) begin
				send_item(FN_TEXT, text_byte());
				sent++;
			end
			send_item(FN_EOL, 8'($urandom_range(0, 255)));
			sent++;
		end
	endtask

	initial begin
		#100000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [KEY_REG_W-1:0] entries;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lines with the longest key of all-ones entries
		write_reg(REG_KEY_LENGTH, KEY_REG_W'(8));
		write_reg(REG_KEY_ENTRIES, {KEY_REG_W{1'b1}});
		foreach (directed_items[i])
			send_item(directed_items[i].func, directed_items[i].char_byte);
		drain();

		// random lines under changing key settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 3)
				entries = '0;
			else if (p == 5)
				entries = {KEY_REG_W{1'b1}};
			else
				entries = KEY_REG_W'({$urandom(), $urandom()});
			in_idle_pct = (p == 4) ? 0 : IDLE_PCT;
			out_idle_pct = (p == 4) ? 0 : IDLE_PCT;
			write_reg(REG_KEY_LENGTH, KEY_REG_W'(PHASE_LEN[p]));
			write_reg(REG_KEY_ENTRIES, entries);
			send_lines(PHASE_ITEMS);
			drain();
		end

		if (sb.errors == 0 && sb.pending_codes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
